// ===== design/wep_fc_pkg.sv =====
// Package with the transaction types, constants and CRC helper of the WEP frame engine.
`timescale 1ns / 1ps

package wep_fc_pkg;

  localparam int IV_BYTES      = 3;
  localparam int ICV_BYTES     = 4;
  localparam int MAX_KEY_BYTES = 13;
  localparam int KEY40_BYTES   = 5;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_PAY  = 2'd1;
  localparam logic [1:0] KIND_ICV  = 2'd2;
  localparam logic [1:0] KIND_STAT = 2'd3;

  localparam logic [2:0] REG_KEY_LOW  = 3'd0;
  localparam logic [2:0] REG_KEY_HIGH = 3'd1;
  localparam logic [2:0] REG_KEY_104  = 3'd2;
  localparam logic [2:0] REG_KEY_IDX  = 3'd3;
  localparam logic [2:0] REG_IV_SEED  = 3'd4;

  typedef struct packed {
    logic       operation;
    logic [7:0] in_byte;
    logic       frame_first;
    logic       frame_last;
  } in_data_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       icv_good;
    logic       end_of_frame;
  } out_data_t;

  // Reflected CRC-32 update over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

// ===== design/wep_frame_crypt.sv =====
// WEP frame body engine: RC4 key scheduling, keystream and CRC-32 ICV over one S-box memory.
`timescale 1ns / 1ps

// The engine takes one frame byte per input transaction and returns zero or more result
// transactions through a registered output stage. All RC4 work goes through a single
// 256x8 S-box memory with one write and one registered read per cycle, driven by a small
// sequencer, so the block accepts a new byte only when the previous one is fully handled.
// A payload byte passes through the accept, a CRC update on encrypt, 6 memory steps for
// the keystream and the emit, and on decrypt it then enters the hold window. A decrypt
// byte that only fills the hold window goes from the accept to the hold step alone.
// Each ICV byte, on an encrypt close or in the decrypt check, runs the keystream steps
// again. Key scheduling at the start of a frame fills the S-box and then swaps through it
// with four memory steps per entry; on encrypt it follows the four header results. On
// decrypt the schedule runs when the key index byte arrives, and the four final bytes
// are held back and checked against the running CRC before a status transaction closes
// the frame.
// Configuration sits on an APB-style port with 64-bit data at byte address 8*i.
module wep_frame_crypt
  import wep_fc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_data_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_data_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Frame phases.
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ENC   = 3'd1;
  localparam logic [2:0] PH_DIV1  = 3'd2;
  localparam logic [2:0] PH_DIV2  = 3'd3;
  localparam logic [2:0] PH_DKID  = 3'd4;
  localparam logic [2:0] PH_DBODY = 3'd5;

  // Sequencer states.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HDR   = 5'd1;
  localparam logic [4:0] S_INIT  = 5'd2;
  localparam logic [4:0] S_KSA0  = 5'd3;
  localparam logic [4:0] S_KSA1  = 5'd4;
  localparam logic [4:0] S_KSA2  = 5'd5;
  localparam logic [4:0] S_KSA3  = 5'd6;
  localparam logic [4:0] S_SDONE = 5'd7;
  localparam logic [4:0] S_ENCB  = 5'd8;
  localparam logic [4:0] S_KS0   = 5'd9;
  localparam logic [4:0] S_KS1   = 5'd10;
  localparam logic [4:0] S_KS2   = 5'd11;
  localparam logic [4:0] S_KS3   = 5'd12;
  localparam logic [4:0] S_KS4   = 5'd13;
  localparam logic [4:0] S_KS5   = 5'd14;
  localparam logic [4:0] S_USE   = 5'd15;
  localparam logic [4:0] S_HOLD  = 5'd16;
  localparam logic [4:0] S_STAT  = 5'd17;

  // What a keystream byte is used for.
  localparam logic [1:0] JOB_ENC_PAY = 2'd0;
  localparam logic [1:0] JOB_ENC_ICV = 2'd1;
  localparam logic [1:0] JOB_DEC_PAY = 2'd2;
  localparam logic [1:0] JOB_DEC_ICV = 2'd3;

  // Configuration registers.
  logic [63:0] key_low_r;
  logic [39:0] key_high_r;
  logic        key_104_r;
  logic [7:0]  key_idx_r;
  logic [23:0] iv_seed_r;

  // S-box memory.
  logic [7:0] sbox_mem [256];
  logic [7:0] rdata_r;
  logic       sbox_we;
  logic [7:0] sbox_waddr, sbox_wdata, sbox_raddr;

  // Sequencer registers.
  logic [4:0]  state_r, state_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  job_r, job_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  a_r, a_nxt;
  logic [3:0]  kp_r, kp_nxt;
  logic [7:0]  i_r, i_nxt;
  logic [7:0]  j_r, j_nxt;
  logic [7:0]  val_r, val_nxt;
  logic [7:0]  sj_r, sj_nxt;
  logic [7:0]  ks_r, ks_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [23:0] iv_ctr_r, iv_ctr_nxt;
  logic [23:0] ivw_r, ivw_nxt;
  logic [23:0] rx_iv_r, rx_iv_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        good_r, good_nxt;
  logic [7:0]  hold_r [ICV_BYTES];
  logic [7:0]  hold_nxt [ICV_BYTES];
  logic [2:0]  hold_cnt_r, hold_cnt_nxt;

  logic        out_valid_r;
  out_data_t   out_data_r;
  logic        emit;
  out_data_t   emit_data;
  logic        can_load;

  logic        cfg_we;
  logic [2:0]  cfg_idx;

  logic [7:0]  kb;
  logic [3:0]  kp_last;
  logic [3:0]  key_pos;
  logic [23:0] iv_pick;
  logic [7:0]  icv_byte;
  logic [7:0]  crc_cmp_byte;
  logic [7:0]  pbyte;
  logic [7:0]  j_step;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_KEY_LOW:  prdata = key_low_r;
      REG_KEY_HIGH: prdata = {24'h0, key_high_r};
      REG_KEY_104:  prdata = {63'h0, key_104_r};
      REG_KEY_IDX:  prdata = {56'h0, key_idx_r};
      REG_IV_SEED:  prdata = {40'h0, iv_seed_r};
      default:      prdata = 64'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sbox_we) begin
      sbox_mem[sbox_waddr] <= sbox_wdata;
    end
    rdata_r <= sbox_mem[sbox_raddr];
  end

  // Byte kp of IV || key.
  assign key_pos = kp_r - 4'd3;
  always_comb begin
    if (kp_r == 4'd0) begin
      kb = ivw_r[23:16];
    end else if (kp_r == 4'd1) begin
      kb = ivw_r[15:8];
    end else if (kp_r == 4'd2) begin
      kb = ivw_r[7:0];
    end else if (key_pos < 4'd8) begin
      kb = key_low_r[{key_pos[2:0], 3'b000} +: 8];
    end else begin
      kb = key_high_r[{key_pos[2:0], 3'b000} +: 8];
    end
  end
  assign kp_last = key_104_r ? 4'(IV_BYTES + MAX_KEY_BYTES - 1) : 4'(IV_BYTES + KEY40_BYTES - 1);

  // Weak IVs of the form (B, 255, N) with B from 3 to 15 jump to (B+1, 0, 0).
  always_comb begin
    iv_pick = iv_ctr_r;
    if (iv_ctr_r[15:8] == 8'hFF && iv_ctr_r[23:16] >= 8'd3 && iv_ctr_r[23:16] < 8'd16) begin
      iv_pick = {iv_ctr_r[23:16] + 8'd1, 16'h0};
    end
  end

  assign icv_byte     = ~crc_r[{cnt_r, 3'b000} +: 8];
  assign crc_cmp_byte = hold_r[cnt_r] ^ ks_r;
  assign pbyte        = hold_r[0] ^ ks_r;
  assign j_step       = j_r + rdata_r;
  assign can_load     = !out_valid_r || out_ready;
  assign in_ready     = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    job_nxt      = job_r;
    cnt_nxt      = cnt_r;
    a_nxt        = a_r;
    kp_nxt       = kp_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    val_nxt      = val_r;
    sj_nxt       = sj_r;
    ks_nxt       = ks_r;
    crc_nxt      = crc_r;
    iv_ctr_nxt   = iv_ctr_r;
    ivw_nxt      = ivw_r;
    rx_iv_nxt    = rx_iv_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    good_nxt     = good_r;
    hold_nxt     = hold_r;
    hold_cnt_nxt = hold_cnt_r;
    sbox_we      = 1'b0;
    sbox_waddr   = a_r;
    sbox_wdata   = a_r;
    sbox_raddr   = a_r;
    emit         = 1'b0;
    emit_data    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.in_byte;
          last_nxt = in_data.frame_last;
          if (in_data.frame_first && !in_data.operation) begin
            ivw_nxt    = iv_pick;
            iv_ctr_nxt = iv_pick + 24'd1;
            cnt_nxt    = 2'd0;
            phase_nxt  = PH_ENC;
            state_nxt  = S_HDR;
          end else if (in_data.frame_first) begin
            rx_iv_nxt = {in_data.in_byte, 16'h0};
            phase_nxt = PH_DIV1;
            if (in_data.frame_last) begin
              good_nxt  = 1'b0;
              state_nxt = S_STAT;
            end
          end else begin
            case (phase_r)
              PH_ENC: state_nxt = S_ENCB;
              PH_DIV1, PH_DIV2: begin
                if (phase_r == PH_DIV1) begin
                  rx_iv_nxt[15:8] = in_data.in_byte;
                  phase_nxt       = PH_DIV2;
                end else begin
                  rx_iv_nxt[7:0] = in_data.in_byte;
                  phase_nxt      = PH_DKID;
                end
                if (in_data.frame_last) begin
                  good_nxt  = 1'b0;
                  state_nxt = S_STAT;
                end
              end
              PH_DKID: begin
                ivw_nxt      = rx_iv_r;
                phase_nxt    = PH_DBODY;
                hold_cnt_nxt = 3'd0;
                a_nxt        = 8'd0;
                state_nxt    = S_INIT;
              end
              PH_DBODY: begin
                if (hold_cnt_r == 3'(ICV_BYTES)) begin
                  job_nxt   = JOB_DEC_PAY;
                  state_nxt = S_KS0;
                end else begin
                  state_nxt = S_HOLD;
                end
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
      end
      S_HDR: begin
        if (can_load) begin
          emit               = 1'b1;
          emit_data.out_kind = KIND_HDR;
          case (cnt_r)
            2'd0:    emit_data.out_byte = ivw_r[23:16];
            2'd1:    emit_data.out_byte = ivw_r[15:8];
            2'd2:    emit_data.out_byte = ivw_r[7:0];
            default: emit_data.out_byte = key_idx_r;
          endcase
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            a_nxt     = 8'd0;
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        sbox_we = 1'b1;
        a_nxt   = a_r + 8'd1;
        if (a_r == 8'hFF) begin
          j_nxt     = 8'd0;
          kp_nxt    = 4'd0;
          state_nxt = S_KSA0;
        end
      end
      S_KSA0: begin
        sbox_raddr = a_r;
        state_nxt  = S_KSA1;
      end
      S_KSA1: begin
        val_nxt    = rdata_r;
        j_nxt      = j_step + kb;
        sbox_raddr = j_step + kb;
        kp_nxt     = (kp_r == kp_last) ? 4'd0 : kp_r + 4'd1;
        state_nxt  = S_KSA2;
      end
      S_KSA2: begin
        sbox_we    = 1'b1;
        sbox_waddr = a_r;
        sbox_wdata = rdata_r;
        state_nxt  = S_KSA3;
      end
      S_KSA3: begin
        sbox_we    = 1'b1;
        sbox_waddr = j_r;
        sbox_wdata = val_r;
        a_nxt      = a_r + 8'd1;
        if (a_r == 8'hFF) begin
          i_nxt     = 8'd0;
          j_nxt     = 8'd0;
          crc_nxt   = CRC_INIT;
          state_nxt = S_SDONE;
        end else begin
          state_nxt = S_KSA0;
        end
      end
      S_SDONE: begin
        if (phase_r == PH_ENC) begin
          state_nxt = S_ENCB;
        end else if (last_r) begin
          good_nxt  = 1'b0;
          state_nxt = S_STAT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ENCB: begin
        crc_nxt   = crc_byte(crc_r, byte_r);
        job_nxt   = JOB_ENC_PAY;
        state_nxt = S_KS0;
      end
      S_KS0: begin
        i_nxt      = i_r + 8'd1;
        sbox_raddr = i_r + 8'd1;
        state_nxt  = S_KS1;
      end
      S_KS1: begin
        val_nxt    = rdata_r;
        j_nxt      = j_step;
        sbox_raddr = j_step;
        state_nxt  = S_KS2;
      end
      S_KS2: begin
        sj_nxt     = rdata_r;
        sbox_we    = 1'b1;
        sbox_waddr = i_r;
        sbox_wdata = rdata_r;
        state_nxt  = S_KS3;
      end
      S_KS3: begin
        sbox_we    = 1'b1;
        sbox_waddr = j_r;
        sbox_wdata = val_r;
        state_nxt  = S_KS4;
      end
      S_KS4: begin
        sbox_raddr = val_r + sj_r;
        state_nxt  = S_KS5;
      end
      S_KS5: begin
        ks_nxt    = rdata_r;
        state_nxt = S_USE;
      end
      S_USE: begin
        case (job_r)
          JOB_ENC_PAY: begin
            if (can_load) begin
              emit               = 1'b1;
              emit_data.out_byte = byte_r ^ ks_r;
              emit_data.out_kind = KIND_PAY;
              if (last_r) begin
                job_nxt   = JOB_ENC_ICV;
                cnt_nxt   = 2'd0;
                state_nxt = S_KS0;
              end else begin
                state_nxt = S_IDLE;
              end
            end
          end
          JOB_ENC_ICV: begin
            if (can_load) begin
              emit                   = 1'b1;
              emit_data.out_byte     = icv_byte ^ ks_r;
              emit_data.out_kind     = KIND_ICV;
              emit_data.end_of_frame = (cnt_r == 2'd3);
              cnt_nxt                = cnt_r + 2'd1;
              if (cnt_r == 2'd3) begin
                phase_nxt = PH_IDLE;
                state_nxt = S_IDLE;
              end else begin
                state_nxt = S_KS0;
              end
            end
          end
          JOB_DEC_PAY: begin
            if (can_load) begin
              emit               = 1'b1;
              emit_data.out_byte = pbyte;
              emit_data.out_kind = KIND_PAY;
              crc_nxt            = crc_byte(crc_r, pbyte);
              for (int k = 0; k < ICV_BYTES - 1; k++) begin
                hold_nxt[k] = hold_r[k + 1];
              end
              hold_cnt_nxt = 3'(ICV_BYTES - 1);
              state_nxt    = S_HOLD;
            end
          end
          default: begin
            // ICV check: each decrypted ICV byte must equal the complemented CRC byte.
            good_nxt = good_r && (crc_cmp_byte == icv_byte);
            cnt_nxt  = cnt_r + 2'd1;
            if (cnt_r == 2'd3) begin
              state_nxt = S_STAT;
            end else begin
              state_nxt = S_KS0;
            end
          end
        endcase
      end
      S_HOLD: begin
        hold_nxt[hold_cnt_r[1:0]] = byte_r;
        hold_cnt_nxt              = hold_cnt_r + 3'd1;
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (hold_cnt_r == 3'(ICV_BYTES - 1)) begin
          job_nxt   = JOB_DEC_ICV;
          cnt_nxt   = 2'd0;
          good_nxt  = 1'b1;
          state_nxt = S_KS0;
        end else begin
          good_nxt  = 1'b0;
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (can_load) begin
          emit                   = 1'b1;
          emit_data.out_kind     = KIND_STAT;
          emit_data.icv_good     = good_r;
          emit_data.end_of_frame = 1'b1;
          phase_nxt              = PH_IDLE;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we && cfg_idx == REG_IV_SEED) begin
      iv_ctr_nxt = pwdata[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      crc_r       <= CRC_INIT;
      iv_ctr_r    <= 24'd0;
      rx_iv_r     <= 24'd0;
      hold_cnt_r  <= 3'd0;
      out_valid_r <= 1'b0;
      key_low_r   <= 64'h0;
      key_high_r  <= 40'h0;
      key_104_r   <= 1'b0;
      key_idx_r   <= 8'h0;
      iv_seed_r   <= 24'h0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      crc_r       <= crc_nxt;
      iv_ctr_r    <= iv_ctr_nxt;
      rx_iv_r     <= rx_iv_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      out_valid_r <= emit || (out_valid_r && !out_ready);
      if (cfg_we) begin
        case (cfg_idx)
          REG_KEY_LOW:  key_low_r  <= pwdata;
          REG_KEY_HIGH: key_high_r <= pwdata[39:0];
          REG_KEY_104:  key_104_r  <= pwdata[0];
          REG_KEY_IDX:  key_idx_r  <= pwdata[7:0];
          REG_IV_SEED:  iv_seed_r  <= pwdata[23:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    cnt_r  <= cnt_nxt;
    a_r    <= a_nxt;
    kp_r   <= kp_nxt;
    val_r  <= val_nxt;
    sj_r   <= sj_nxt;
    ks_r   <= ks_nxt;
    ivw_r  <= ivw_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    good_r <= good_nxt;
    hold_r <= hold_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/wep_frame_crypt_tb.sv =====
// Self-checking testbench for the WEP frame engine with a built-in RC4 and CRC-32 predictor.
`timescale 1ns / 1ps

module wep_frame_crypt_tb;
  import wep_fc_pkg::*;

  // Frame phases of the predictor, in the order the engine walks through them.
  typedef enum logic [2:0] {
    FR_IDLE, FR_ENC, FR_DIV1, FR_DIV2, FR_DKID, FR_DBODY
  } frame_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_data_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_data_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  wep_frame_crypt u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Byte transactions waiting to be offered, and results the predictor says must come.
  in_data_t  byte_queue[$];
  out_data_t expected_results[$];
  int        errors = 0;
  int        results_seen = 0;
  int        frames_built = 0;
  int        items_built = 0;

  // Idle control: the initial block can switch off random gaps on either side, and it
  // can ask the receiver to hold off for a long stretch that the stall counter times.
  bit tx_no_gaps = 1'b0;
  bit rx_no_gaps = 1'b0;
  bit stall_trigger = 1'b0;
  bit stall_seen = 1'b0;
  int stall_left = 0;

  // Shadow of the configuration registers and of the engine state.
  logic [63:0]  key_low_q;
  logic [39:0]  key_high_q;
  logic         key_wide_q;
  logic [7:0]   key_idx_q;
  logic [23:0]  iv_count_q;
  logic [7:0]   sbox_q[256];
  logic [7:0]   ks_i, ks_j;
  logic [31:0]  crc_q;
  logic [7:0]   icv_hold[4];
  int           hold_n;
  logic [23:0]  rx_iv_q;
  frame_phase_t phase_q;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void crc_add(input logic [7:0] b);
    crc_q = crc_q ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      crc_q = (crc_q >> 1) ^ (crc_q[0] ? 32'hEDB88320 : 32'h0);
    end
  endfunction

  function automatic logic [7:0] secret_byte(input int k);
    if (k < 8) return key_low_q[8*k +: 8];
    return key_high_q[8*(k-8) +: 8];
  endfunction

  function automatic void rc4_schedule(input logic [23:0] iv);
    logic [7:0] seed[16];
    logic [7:0] j;
    logic [7:0] t;
    int         len;
    len = IV_BYTES + (key_wide_q ? MAX_KEY_BYTES : KEY40_BYTES);
    seed[0] = iv[23:16];
    seed[1] = iv[15:8];
    seed[2] = iv[7:0];
    for (int k = 0; k < len - IV_BYTES; k++) seed[IV_BYTES + k] = secret_byte(k);
    for (int a = 0; a < 256; a++) sbox_q[a] = a[7:0];
    j = 8'd0;
    for (int a = 0; a < 256; a++) begin
      j = j + sbox_q[a] + seed[a % len];
      t = sbox_q[a];
      sbox_q[a] = sbox_q[j];
      sbox_q[j] = t;
    end
    ks_i = 8'd0;
    ks_j = 8'd0;
    crc_q = 32'hFFFFFFFF;
  endfunction

  function automatic logic [7:0] rc4_next();
    logic [7:0] t;
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + sbox_q[ks_i];
    t = sbox_q[ks_i];
    sbox_q[ks_i] = sbox_q[ks_j];
    sbox_q[ks_j] = t;
    return sbox_q[sbox_q[ks_i] + sbox_q[ks_j]];
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic [1:0] kind,
                                      input logic good, input logic eof);
    out_data_t r;
    r.out_byte = b;
    r.out_kind = kind;
    r.icv_good = good;
    r.end_of_frame = eof;
    expected_results.push_back(r);
  endfunction

  // Works out every result that one accepted byte causes.
  function automatic void wep_predict(input in_data_t d);
    logic [23:0] iv;
    logic [31:0] icv;
    logic [31:0] v;
    logic [7:0]  p;
    logic        good;
    if (d.frame_first) begin
      if (!d.operation) begin
        iv = iv_count_q;
        // Weak IVs (B, 255, N) with B from 3 to 15 jump to the next B.
        if (iv[15:8] == 8'hFF && iv[23:16] >= 8'd3 && iv[23:16] < 8'd16)
          iv = {iv[23:16] + 8'd1, 16'h0};
        iv_count_q = iv + 24'd1;
        push_result(iv[23:16], KIND_HDR, 1'b0, 1'b0);
        push_result(iv[15:8], KIND_HDR, 1'b0, 1'b0);
        push_result(iv[7:0], KIND_HDR, 1'b0, 1'b0);
        push_result(key_idx_q, KIND_HDR, 1'b0, 1'b0);
        rc4_schedule(iv);
        phase_q = FR_ENC;
      end else begin
        rx_iv_q = {d.in_byte, 16'h0};
        phase_q = FR_DIV1;
        if (d.frame_last) begin
          push_result(8'h0, KIND_STAT, 1'b0, 1'b1);
          phase_q = FR_IDLE;
        end
        return;
      end
    end
    case (phase_q)
      FR_ENC: begin
        crc_add(d.in_byte);
        push_result(d.in_byte ^ rc4_next(), KIND_PAY, 1'b0, 1'b0);
        if (d.frame_last) begin
          icv = ~crc_q;
          for (int k = 0; k < ICV_BYTES; k++)
            push_result(icv[8*k +: 8] ^ rc4_next(), KIND_ICV, 1'b0, k == ICV_BYTES - 1);
          phase_q = FR_IDLE;
        end
        return;
      end
      FR_DIV1: begin
        rx_iv_q[15:8] = d.in_byte;
        phase_q = FR_DIV2;
      end
      FR_DIV2: begin
        rx_iv_q[7:0] = d.in_byte;
        phase_q = FR_DKID;
      end
      FR_DKID: begin
        rc4_schedule(rx_iv_q);
        hold_n = 0;
        phase_q = FR_DBODY;
      end
      FR_DBODY: begin
        // The last four bytes stay in the hold window until the frame closes.
        if (hold_n >= ICV_BYTES) begin
          p = icv_hold[0] ^ rc4_next();
          crc_add(p);
          push_result(p, KIND_PAY, 1'b0, 1'b0);
          for (int k = 0; k < ICV_BYTES - 1; k++) icv_hold[k] = icv_hold[k+1];
          hold_n = ICV_BYTES - 1;
        end
        icv_hold[hold_n] = d.in_byte;
        hold_n++;
        if (d.frame_last) begin
          good = 1'b0;
          if (hold_n == ICV_BYTES) begin
            v = '0;
            for (int k = 0; k < ICV_BYTES; k++) v[8*k +: 8] = icv_hold[k] ^ rc4_next();
            good = (crc_q == ~v);
          end
          push_result(8'h0, KIND_STAT, good, 1'b1);
          phase_q = FR_IDLE;
        end
        return;
      end
      default: begin
        phase_q = FR_IDLE;
        return;
      end
    endcase
    if (d.frame_last) begin
      push_result(8'h0, KIND_STAT, 1'b0, 1'b1);
      phase_q = FR_IDLE;
    end
  endfunction

  // Sender: takes the next byte from the queue, with random gaps unless told otherwise.
  always @(posedge clk) begin
    logic     done;
    logic     next_valid;
    in_data_t next_data;
    if (rst_n) begin
      done = in_valid && in_ready;
      if (done) wep_predict(in_data);
      next_valid = in_valid && !done;
      next_data = in_data;
      if (!next_valid && byte_queue.size() > 0 &&
          (tx_no_gaps || $urandom_range(99) >= 30)) begin
        next_valid = 1'b1;
        next_data = byte_queue.pop_front();
      end
      in_valid <= next_valid;
      in_data <= next_data;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (stall_left == 0 && stall_trigger != stall_seen) begin
      stall_left <= 600;
      stall_seen <= stall_trigger;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    out_data_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data.out_byte, want.out_byte);
          if (out_data.out_kind !== want.out_kind)
            report_mismatch("out_kind", out_data.out_kind, want.out_kind);
          if (out_data.icv_good !== want.icv_good)
            report_mismatch("icv_good", out_data.icv_good, want.icv_good);
          if (out_data.end_of_frame !== want.end_of_frame)
            report_mismatch("end_of_frame", out_data.end_of_frame, want.end_of_frame);
        end
      end
      out_ready <= (stall_left == 0) && (rx_no_gaps || $urandom_range(99) >= 30);
    end
  end

  function automatic void add_byte(input logic op, input logic [7:0] b,
                                   input logic first, input logic last);
    in_data_t d;
    d.operation = op;
    d.in_byte = b;
    d.frame_first = first;
    d.frame_last = last;
    byte_queue.push_back(d);
    items_built++;
  endfunction

  // Encrypt frame of random plaintext; the operation bit is random after the first byte
  // since the engine only looks at it on a first mark. With close = 0 the frame is left
  // open so that the next first mark drops it.
  function automatic void add_encrypt_frame(input int len, input bit close);
    for (int k = 0; k < len; k++)
      add_byte(k == 0 ? 1'b0 : 1'($urandom), 8'($urandom), k == 0,
               close && k == len - 1);
    frames_built++;
  endfunction

  // Decrypt frame of random bytes, mostly too short or with a bad ICV.
  function automatic void add_raw_decrypt(input int len);
    for (int k = 0; k < len; k++)
      add_byte(k == 0 ? 1'b1 : 1'($urandom), 8'($urandom), k == 0, k == len - 1);
    frames_built++;
  endfunction

  // Builds a properly sealed frame under the current key and queues it for decryption.
  // The engine shadow is saved around the work so the predictor is left untouched.
  function automatic void add_sealed_decrypt(input int len, input bit corrupt);
    logic [7:0]  saved_sbox[256];
    logic [7:0]  saved_i, saved_j;
    logic [31:0] saved_crc;
    logic [23:0] iv;
    logic [7:0]  plain;
    logic [31:0] icv;
    logic [7:0]  wire_bytes[$];
    int          n;
    saved_sbox = sbox_q;
    saved_i = ks_i;
    saved_j = ks_j;
    saved_crc = crc_q;
    iv = 24'($urandom);
    wire_bytes.push_back(iv[23:16]);
    wire_bytes.push_back(iv[15:8]);
    wire_bytes.push_back(iv[7:0]);
    wire_bytes.push_back(8'($urandom));
    rc4_schedule(iv);
    for (int k = 0; k < len; k++) begin
      plain = 8'($urandom);
      crc_add(plain);
      wire_bytes.push_back(plain ^ rc4_next());
    end
    icv = ~crc_q;
    for (int k = 0; k < ICV_BYTES; k++) wire_bytes.push_back(icv[8*k +: 8] ^ rc4_next());
    sbox_q = saved_sbox;
    ks_i = saved_i;
    ks_j = saved_j;
    crc_q = saved_crc;
    n = wire_bytes.size();
    if (corrupt) wire_bytes[$urandom_range(n - 1, 4)] ^= 8'(1 << $urandom_range(7));
    for (int k = 0; k < n; k++)
      add_byte(k == 0 ? 1'b1 : 1'($urandom), wire_bytes[k], k == 0, k == n - 1);
    frames_built++;
  endfunction

  // Mostly well-formed frames with random content, the rest noise and broken frames.
  // Every batch ends on a closed frame so the engine is idle once its results are out.
  function automatic void add_random_traffic(input int count);
    int stop;
    int pick;
    stop = items_built + count;
    while (items_built < stop) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        add_encrypt_frame($urandom_range(10, 1), 1'b1);
      end else if (pick < 75) begin
        add_sealed_decrypt($urandom_range(8), $urandom_range(3) == 0);
      end else if (pick < 85) begin
        add_raw_decrypt($urandom_range(8, 1));
      end else if (pick < 92) begin
        // Stray bytes between frames are dropped and do not count.
        add_byte(1'($urandom), 8'($urandom), 1'b0, 1'($urandom));
        items_built--;
      end else begin
        add_encrypt_frame($urandom_range(4, 1), 1'b0);
      end
    end
    add_encrypt_frame($urandom_range(3, 1), 1'b1);
  endfunction

  // APB write: setup cycle, then an access cycle; pready is always high.
  task automatic cfg_write(input logic [2:0] index, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_KEY_LOW:  key_low_q = value;
      REG_KEY_HIGH: key_high_q = value[39:0];
      REG_KEY_104:  key_wide_q = value[0];
      REG_KEY_IDX:  key_idx_q = value[7:0];
      REG_IV_SEED:  iv_count_q = value[23:0];
      default: ;
    endcase
  endtask

  task automatic set_key(input logic [63:0] lo, input logic [39:0] hi, input logic wide,
                         input logic [7:0] idx, input logic [23:0] seed);
    cfg_write(REG_KEY_LOW, lo);
    cfg_write(REG_KEY_HIGH, {24'h0, hi});
    cfg_write(REG_KEY_104, {63'h0, wide});
    cfg_write(REG_KEY_IDX, {56'h0, idx});
    cfg_write(REG_IV_SEED, {40'h0, seed});
  endtask

  // The sender pauses here until every queued byte is taken and every result is in. The
  // engine may still be scheduling after the last result, so some extra cycles follow.
  task automatic wait_drained();
    while (byte_queue.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  initial begin
    key_low_q = '0;
    key_high_q = '0;
    key_wide_q = 1'b0;
    key_idx_q = '0;
    iv_count_q = '0;
    ks_i = '0;
    ks_j = '0;
    crc_q = 32'hFFFFFFFF;
    hold_n = 0;
    rx_iv_q = '0;
    phase_q = FR_IDLE;
    for (int k = 0; k < ICV_BYTES; k++) icv_hold[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: zero key, 40-bit, and a seed that lands on a weak IV.
    set_key(64'h0, 40'h0, 1'b0, 8'h00, 24'h03FF00);
    add_byte(1'b0, 8'hFF, 1'b0, 1'b0);          // stray byte while idle
    add_byte(1'b0, 8'h00, 1'b1, 1'b1);          // one-byte encrypt frames
    add_byte(1'b0, 8'hFF, 1'b1, 1'b1);
    add_byte(1'b0, 8'h5A, 1'b1, 1'b0);          // operation flips mid-frame
    add_byte(1'b1, 8'hA5, 1'b0, 1'b0);
    add_byte(1'b0, 8'h3C, 1'b0, 1'b1);
    add_byte(1'b0, 8'h11, 1'b1, 1'b0);          // open frame dropped by a new first mark
    add_byte(1'b0, 8'h22, 1'b0, 1'b0);
    add_encrypt_frame(2, 1'b1);
    add_byte(1'b1, 8'h80, 1'b1, 1'b1);          // decrypt ending on its first byte
    add_raw_decrypt(3);                         // decrypt ending inside the header
    add_raw_decrypt(6);                         // decrypt shorter than header plus ICV
    add_sealed_decrypt(1, 1'b0);                // decrypt with a good ICV
    wait_drained();

    // Widest key, all-ones extremes, and a seed just below the counter wrap.
    set_key(64'hFFFF_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, 8'hFF, 24'hFFFFFE);
    rx_no_gaps = 1'b1;
    tx_no_gaps = 1'b1;
    add_random_traffic(95);
    wait_drained();
    rx_no_gaps = 1'b0;
    tx_no_gaps = 1'b0;

    // Random 40-bit key near the top weak range; the receiver holds off while the
    // sender keeps offering, so the engine fills and stalls its input.
    set_key({$urandom, $urandom}, 40'($urandom), 1'b0, 8'($urandom), 24'h0EFF00);
    stall_trigger = ~stall_trigger;
    add_random_traffic(95);
    wait_drained();

    // Random 104-bit key with a random seed.
    set_key({$urandom, $urandom}, {8'($urandom), 32'($urandom)}, 1'b1, 8'($urandom),
            24'($urandom));
    add_random_traffic(95);
    wait_drained();

    $display("Ran %0d byte transactions in %0d frames, %0d results checked.",
             items_built, frames_built, results_seen);
    $display("Covered both key lengths, weak IV skips, counter wrap and broken frames.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== wep_frame_crypt.f =====
design/wep_fc_pkg.sv
design/wep_frame_crypt.sv
verif/wep_frame_crypt_tb.sv
